/* rtl/pumt_pkg.sv */
// Shared types and constants for the point-update minimum tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package pumt_pkg;

   // Field widths of the request and response.
   localparam int DATA_W      = 32;
   localparam int SLOT_W      = 10;
   localparam int CNT_W       = 11;
   localparam int REQ_TDATA_W = 48;

   // Configuration port geometry and register index.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ENTRIES = 1'b0;

   // Empty marker and reset values.
   localparam logic [DATA_W-1:0] EMPTY_VALUE   = {DATA_W{1'b1}};
   localparam logic [CNT_W-1:0]  ENTRIES_RESET = 11'd1024;
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_start;   // restart the clearing sweep, empty the minimum
      logic clear_wr;      // write one empty entry and advance the counter
      logic take_req;      // capture a request and read its old entry
      logic do_check;      // write the new value and fold it into the minimum
      logic scan_start;    // start a rescan from entry zero
      logic scan_rd;       // read one entry of the rescan
      logic scan_done;     // finish the rescan and publish the minimum
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_bad;      // request slot lies outside the entries in use
      logic need_rescan;   // overwritten entry held the minimum
      logic clear_last;    // sweep counter is on the last table entry
      logic scan_last;     // rescan counter is on the last entry in use
      logic out_free;      // response register can take a new result
   } sts_type;

endpackage

/* rtl/pumt_ctrl.sv */
// Controller state machine of the point-update minimum tracker.
// Depends on pumt_pkg for the command and status structs.
module pumt_ctrl import pumt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    cfg_wr,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state, commands and request ready.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      if (cfg_wr) begin
         // A new entry count starts a fresh table.
         cmd.clear_start = 1'b1;
         state_in        = ST_CLEAR;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               cmd.clear_wr = 1'b1;
               if (sts.clear_last) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               req_tready = sts.out_free;
               if (req_tvalid && sts.out_free) begin
                  cmd.take_req = 1'b1;
                  if (!sts.slot_bad) begin
                     state_in = ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               cmd.do_check = 1'b1;
               if (sts.need_rescan) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_SCAN: begin
               cmd.scan_rd = 1'b1;
               if (sts.scan_last) begin
                  state_in = ST_FINISH;
               end
            end
            ST_FINISH: begin
               cmd.scan_done = 1'b1;
               state_in      = ST_IDLE;
            end
            default: begin
               cmd.clear_start = 1'b1;
               state_in        = ST_CLEAR;
            end
         endcase
      end
   end

   // State register; reset begins with the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/pumt_dp.sv */
// Datapath of the point-update minimum tracker: value table memory, sweep
// counter, minimum register, rescan accumulator and response register.
// Depends on pumt_pkg for widths, constants and the command and status structs.
module pumt_dp import pumt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [DATA_W-1:0] req_value,
   input  logic [CNT_W-1:0]  entries_in_use,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [DATA_W-1:0] rsp_min,
   output logic              rsp_bad
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int DW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (DW > CNT_W) ? DW : CNT_W;
   localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   logic [DATA_W-1:0] value_table_ff [TABLE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]     cnt_ff;
   logic [AW-1:0]     cnt_in;
   logic [AW-1:0]     slot_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] min_ff;
   logic [DATA_W-1:0] min_in;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;
   logic              scan_pend_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [DATA_W-1:0] out_min_ff;
   logic [DATA_W-1:0] out_min_in;
   logic              out_bad_ff;
   logic              out_bad_in;

   logic [CW-1:0]     entries_ext;
   logic [CW-1:0]     active_n;
   logic [CW-1:0]     slot_ext;
   logic [AW-1:0]     req_addr;
   logic [DATA_W-1:0] min_merged;
   logic [DATA_W-1:0] scan_min;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic              mem_re;
   logic [AW-1:0]     mem_ra;

   // Active entry count, saturated at the table depth, and the slot check.
   always_comb begin
      entries_ext = CW'(entries_in_use);
      active_n    = (entries_ext > DEPTH_C) ? DEPTH_C : entries_ext;
      slot_ext    = CW'(req_slot);
      req_addr    = slot_ext[AW-1:0];
   end

   // Minimum after the new value and the running minimum of the rescan.
   always_comb begin
      min_merged = (value_ff < min_ff) ? value_ff : min_ff;
      scan_min   = (rd_data_ff < acc_ff) ? rd_data_ff : acc_ff;
      acc_in     = scan_pend_ff ? scan_min : acc_ff;
   end

   // Status to the controller.
   always_comb begin
      sts.slot_bad    = (slot_ext >= active_n);
      sts.need_rescan = (rd_data_ff == min_merged);
      sts.clear_last  = (cnt_ff == LAST_ADDR);
      sts.scan_last   = (CW'(cnt_ff) == (active_n - CW'(1)));
      sts.out_free    = !out_valid_ff || rsp_tready;
   end

   // Memory port selection: the sweep and the check write, the request and
   // the rescan read.
   always_comb begin
      mem_we = cmd.clear_wr || cmd.do_check;
      mem_wa = cmd.clear_wr ? cnt_ff : slot_ff;
      mem_wd = cmd.clear_wr ? EMPTY_VALUE : value_ff;
      mem_re = cmd.take_req || cmd.scan_rd;
      mem_ra = cmd.take_req ? req_addr : cnt_ff;
   end

   // Value table with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_table_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= value_table_ff[mem_ra];
      end
   end

   // Sweep counter and minimum register next values.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_start || cmd.scan_start) begin
         cnt_in = '0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
         cnt_in = cnt_ff + AW'(1);
      end
      min_in = min_ff;
      if (cmd.clear_start) begin
         min_in = EMPTY_VALUE;
      end else if (cmd.do_check) begin
         min_in = min_merged;
      end else if (cmd.scan_done) begin
         min_in = scan_min;
      end
   end

   // Response register: loaded on a bad slot, a check without rescan, or
   // the end of a rescan; emptied when the response is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_min_in   = out_min_ff;
      out_bad_in   = out_bad_ff;
      if (cmd.take_req && sts.slot_bad) begin
         out_valid_in = 1'b1;
         out_min_in   = min_ff;
         out_bad_in   = 1'b1;
      end else if (cmd.do_check && !sts.need_rescan) begin
         out_valid_in = 1'b1;
         out_min_in   = min_merged;
         out_bad_in   = 1'b0;
      end else if (cmd.scan_done) begin
         out_valid_in = 1'b1;
         out_min_in   = scan_min;
         out_bad_in   = 1'b0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         min_ff       <= EMPTY_VALUE;
         scan_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         scan_pend_ff <= cmd.scan_rd;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         slot_ff  <= req_addr;
         value_ff <= req_value;
      end
      acc_ff     <= cmd.scan_start ? EMPTY_VALUE : acc_in;
      out_min_ff <= out_min_in;
      out_bad_ff <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_min    = out_min_ff;
   assign rsp_bad    = out_bad_ff;

endmodule

/* rtl/point_update_min_tracker_top.sv */
// Point-update minimum tracker. An in-range request reads its old entry when accepted in IDLE
// and is answered from CHECK, after which the next request can be taken; when the overwritten
// entry held the minimum, a SCAN of the active entries through the single read port of the
// value table and a FINISH step come first. An out-of-range request is answered in the next
// cycle, one per cycle while responses are taken. Reset (synchronous, active high) and every
// write of entries_in_use start a clearing sweep of all TABLE_DEPTH entries, taking no request.
module point_update_min_tracker_top import pumt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] slot, [41:10] new_value
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [31:0] current_min
   output logic                   rsp_tuser,   // [0] bad_slot
   // Configuration port.
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [CNT_W-1:0] entries_ff;
   logic             cfg_wr;
   cmd_type          dp_cmd;
   sts_type          dp_sts;

   // Register file: one register, entries_in_use, at byte addresses zero to three (paddr[2] low).
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1] == REG_ENTRIES);
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_ENTRIES) ? CSR_DATA_W'(entries_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (cfg_wr) begin
         entries_ff <= pwdata[CNT_W-1:0];
      end
   end

   // Controller.
   pumt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cfg_wr     (cfg_wr),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   // Datapath.
   pumt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_slot       (req_tdata[SLOT_W-1:0]),
      .req_value      (req_tdata[SLOT_W+DATA_W-1:SLOT_W]),
      .entries_in_use (entries_ff),
      .cmd            (dp_cmd),
      .sts            (dp_sts),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_min        (rsp_tdata),
      .rsp_bad        (rsp_tuser)
   );

   // An out-of-range request is answered, flagged, in the next cycle.
   a_bad_slot_answer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && dp_sts.slot_bad) |=> (rsp_tvalid && rsp_tuser))
      else $error("out-of-range request not answered in the next cycle");

   // An in-range request leaves the response register empty while the controller is in CHECK.
   a_good_slot_wait: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !dp_sts.slot_bad) |=> !rsp_tvalid)
      else $error("in-range request answered too early");

   // A register write starts the clearing sweep and blocks requests.
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_tready)
      else $error("request taken right after an entry count write");

endmodule
